[design/jbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_pkg - shared types and constants for the JSON byte tokenizer
// Result codes, token codes, character constants and the beat structures
// passed between the decoder, the result queue and the top level.
// ----------------------------------------------------------------------------
package jbt_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // Token codes
    typedef enum logic [3:0] {
        TOK_ARRAY_START = 4'd0,
        TOK_ARRAY_END   = 4'd1,
        TOK_CURLY_START = 4'd2,
        TOK_CURLY_END   = 4'd3,
        TOK_STRING      = 4'd4,
        TOK_NUMBER      = 4'd5,
        TOK_BOOLEAN     = 4'd6,
        TOK_COLON       = 4'd7,
        TOK_COMMA       = 4'd8,
        TOK_NULL        = 4'd9
    } tok_t;

    // Error codes
    typedef enum logic {
        ERR_NUM_BOOL   = 1'b0,
        ERR_UNFINISHED = 1'b1
    } err_t;

    // Character constants
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Result queue depth; a byte needs room for two beats
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One result beat
    typedef struct packed {
        kind_t      kind;
        tok_t       tok;
        logic [7:0] ch;
        err_t       err;
        logic       last;
    } result_t;

    // Tokenizer state
    typedef struct packed {
        logic in_string;
        logic number_seen;
        logic bool_seen;
        logic value_pending;
        logic halted;
    } tstate_t;

    // Decoder output: up to two beats
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } dec_out_t;

endpackage

[design/json_byte_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_byte_tokenizer_unit - streaming JSON byte tokenizer
// Path: an accepted byte is held in the input register, then its result
// beats are written into the result queue, which drives the output port.
// Throughput: one byte per cycle while the queue has room for two beats; the output
// port moves one beat per cycle while out_ready is high, so a byte giving two beats takes two transfers.
// Reset: asynchronous active-low clears tokenizer state, stage and queue.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [3:0] token_type,
    output logic [7:0] value_char,
    output logic       error_code,
    output logic       last
);
    import jbt_pkg::*;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    logic [7:0] char_reg;
    logic       eoi_reg;
    tstate_t    st_reg;
    tstate_t    st_next;
    dec_out_t   dout;
    result_t    head;
    logic       q_not_empty;
    logic       q_room2;
    logic       advance;
    logic       in_fire;

    // Stage handshake: the registered byte moves on when the queue has room
    assign advance  = stage_valid_reg && q_room2;
    assign in_ready = !stage_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign stage_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            st_reg          <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= char_code;
            eoi_reg  <= end_of_input;
        end
    end

    // Byte decision
    jbt_decode u_decode (
        .char_code    (char_reg),
        .end_of_input (eoi_reg),
        .st           (st_reg),
        .st_next      (st_next),
        .dout         (dout)
    );

    // Result queue
    jbt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (dout),
        .push      (advance),
        .pop       (out_valid && out_ready),
        .head      (head),
        .not_empty (q_not_empty),
        .room2     (q_room2)
    );

    // Output beat
    assign out_valid   = q_not_empty;
    assign result_kind = head.kind;
    assign token_type  = head.tok;
    assign value_char  = head.ch;
    assign error_code  = head.err;
    assign last        = head.last;

endmodule

[design/jbt_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_decode - per-byte tokenizer decision
// From the registered byte and the current state, produces the next state
// and zero, one or two result beats.
// ----------------------------------------------------------------------------
module jbt_decode (
    input  logic [7:0]       char_code,
    input  logic             end_of_input,
    input  jbt_pkg::tstate_t st,
    output jbt_pkg::tstate_t st_next,
    output jbt_pkg::dec_out_t dout
);
    import jbt_pkg::*;

    logic    is_blank;
    logic    is_num;
    logic    is_bool;
    tok_t    val_tok;
    result_t tok_beat;
    result_t val_beat;
    result_t char_beat;

    // Character classes
    assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                      (char_code == CH_LF) || (char_code == CH_CR);
    assign is_num   = (char_code == CH_MINUS) || (char_code == CH_DOT) ||
                      ((char_code >= CH_ZERO) && (char_code <= CH_NINE));
    assign is_bool  = (char_code == CH_LOW_T) || (char_code == CH_UP_T) ||
                      (char_code == CH_LOW_F) || (char_code == CH_UP_F);

    // Value token chosen when a delimiter closes a pending value
    assign val_tok = st.number_seen ? TOK_NUMBER :
                     (st.bool_seen ? TOK_BOOLEAN : TOK_NULL);

    always_comb
    begin
        tok_beat        = '0;
        tok_beat.kind   = KIND_TOKEN;
        val_beat        = '0;
        val_beat.kind   = KIND_TOKEN;
        val_beat.tok    = val_tok;
        char_beat       = '0;
        char_beat.kind  = KIND_CHAR;
        char_beat.ch    = char_code;

        st_next    = st;
        dout       = '0;

        if (!st.halted)
        begin
            if (end_of_input)
            begin
                dout.count = 2'd1;
                if (st.number_seen || st.in_string || st.bool_seen || st.value_pending)
                begin
                    st_next.halted = 1'b1;
                    dout.r0.kind   = KIND_ERROR;
                    dout.r0.err    = ERR_UNFINISHED;
                end
                else
                begin
                    dout.r0.kind = KIND_END;
                end
            end
            else if ((char_code == CH_COMMA) && st.number_seen && st.bool_seen)
            begin
                st_next.halted = 1'b1;
                dout.count     = 2'd1;
                dout.r0.kind   = KIND_ERROR;
                dout.r0.err    = ERR_NUM_BOOL;
            end
            else if (char_code == CH_QUOTE)
            begin
                if (st.in_string)
                begin
                    st_next.in_string     = 1'b0;
                    st_next.value_pending = 1'b0;
                    tok_beat.tok          = TOK_STRING;
                    dout.count            = 2'd1;
                    dout.r0               = tok_beat;
                end
                else
                begin
                    st_next.in_string = 1'b1;
                end
            end
            else if (st.in_string)
            begin
                // Any other byte inside a string is a plain character
                st_next.value_pending = 1'b1;
                dout.count            = 2'd1;
                dout.r0               = char_beat;
            end
            else
            begin
                case (char_code)
                    CH_LCURLY, CH_LBRACK, CH_COLON:
                    begin
                        tok_beat.tok = (char_code == CH_LCURLY) ? TOK_CURLY_START :
                                       ((char_code == CH_LBRACK) ? TOK_ARRAY_START
                                                                 : TOK_COLON);
                        dout.count = 2'd1;
                        dout.r0    = tok_beat;
                    end
                    CH_RCURLY, CH_RBRACK, CH_COMMA:
                    begin
                        tok_beat.tok = (char_code == CH_RCURLY) ? TOK_CURLY_END :
                                       ((char_code == CH_RBRACK) ? TOK_ARRAY_END
                                                                 : TOK_COMMA);
                        if (st.value_pending)
                        begin
                            // Close the value first; clear only the chosen flag
                            if (st.number_seen)
                                st_next.number_seen = 1'b0;
                            else if (st.bool_seen)
                                st_next.bool_seen = 1'b0;
                            st_next.value_pending = 1'b0;
                            dout.count = 2'd2;
                            dout.r0    = val_beat;
                            dout.r1    = tok_beat;
                        end
                        else
                        begin
                            dout.count = 2'd1;
                            dout.r0    = tok_beat;
                        end
                    end
                    default:
                    begin
                        if (!is_blank)
                        begin
                            st_next.value_pending = 1'b1;
                            if (is_num)
                                st_next.number_seen = 1'b1;
                            else if (is_bool)
                                st_next.bool_seen = 1'b1;
                            dout.count = 2'd1;
                            dout.r0    = char_beat;
                        end
                    end
                endcase
            end
        end

        // Mark the final beat of this byte
        if (dout.count == 2'd1)
            dout.r0.last = 1'b1;
        else if (dout.count == 2'd2)
            dout.r1.last = 1'b1;
    end

endmodule

[design/jbt_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_result_fifo - small result queue
// Takes up to two beats per cycle from the decoder on a push and presents one beat
// per cycle on the output handshake while it is popped.
// ----------------------------------------------------------------------------
module jbt_result_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  jbt_pkg::dec_out_t             din,
    input  logic                          push,
    input  logic                          pop,
    output jbt_pkg::result_t              head,
    output logic                          not_empty,
    output logic                          room2
);
    import jbt_pkg::*;

    result_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QCNT_W-1:0]   push_cnt;
    logic [QPTR_W-1:0]   wr_ptr_p1;

    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign push_cnt  = push ? QCNT_W'(din.count) : '0;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + push_cnt - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != '0)
            mem_reg[wr_ptr_reg] <= din.r0;
        if (push_cnt == QCNT_W'(2))
            mem_reg[wr_ptr_p1] <= din.r1;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for json_byte_tokenizer_unit
// Feeds JSON text one byte per beat, models the tokenizer state in the bench
// and checks every result beat in order. Covers directed token and string
// cases, random well-formed documents mixed with byte noise, random stalls on
// both sides, a long receiver hold-off, and the halt after an error at the very end.
// ----------------------------------------------------------------------------
module testbench;
    import jbt_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;
    localparam logic [7:0] CH_FILLER = 8'h78;   // plain letter, no flags

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] char_code    = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [1:0] result_kind;
    logic [3:0] token_type;
    logic [7:0] value_char;
    logic       error_code;
    logic       last;

    // Tokenizer state as the bench sees it
    bit inside_quotes   = 1'b0;
    bit saw_digit       = 1'b0;
    bit saw_bool_letter = 1'b0;
    bit value_open      = 1'b0;
    bit stopped         = 1'b0;

    result_t token_stream_q[$];
    result_t step_beats [2];
    int      step_n;
    int      result_items = 0;
    int      error_count  = 0;
    int      stall_cycles = 0;
    int      tx_idle_pct  = 0;
    int      rx_idle_pct  = 0;
    bit      hold_req     = 1'b0;
    bit      hold_ack     = 1'b0;
    int      hold_left    = 0;

    json_byte_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .token_type   (token_type),
        .value_char   (value_char),
        .error_code   (error_code),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    task automatic add_beat(input kind_t k, input tok_t t, input logic [7:0] c,
                            input err_t e);
        step_beats[step_n].kind = k;
        step_beats[step_n].tok  = t;
        step_beats[step_n].ch   = c;
        step_beats[step_n].err  = e;
        step_beats[step_n].last = 1'b0;
        step_n++;
    endtask

    // Close a pending value (flag priority: number, boolean, null) then the delimiter
    task automatic close_value(input tok_t delim);
        if (value_open)
        begin
            if (saw_digit)
            begin
                saw_digit = 1'b0;
                add_beat(KIND_TOKEN, TOK_NUMBER, 8'h00, ERR_NUM_BOOL);
            end
            else if (saw_bool_letter)
            begin
                saw_bool_letter = 1'b0;
                add_beat(KIND_TOKEN, TOK_BOOLEAN, 8'h00, ERR_NUM_BOOL);
            end
            else
            begin
                add_beat(KIND_TOKEN, TOK_NULL, 8'h00, ERR_NUM_BOOL);
            end
            value_open = 1'b0;
        end
        add_beat(KIND_TOKEN, delim, 8'h00, ERR_NUM_BOOL);
    endtask

    task automatic keep_value_char(input logic [7:0] c);
        value_open = 1'b1;
        // flags are only set outside quotes and never cleared here
        if (!inside_quotes)
        begin
            if (c == CH_MINUS || c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE))
                saw_digit = 1'b1;
            else if (c == CH_LOW_T || c == CH_UP_T || c == CH_LOW_F || c == CH_UP_F)
                saw_bool_letter = 1'b1;
        end
        add_beat(KIND_CHAR, TOK_ARRAY_START, c, ERR_NUM_BOOL);
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
        step_n = 0;
        if (!stopped)
        begin
            if (eoi)
            begin
                if (saw_digit || inside_quotes || saw_bool_letter || value_open)
                begin
                    stopped = 1'b1;
                    add_beat(KIND_ERROR, TOK_ARRAY_START, 8'h00, ERR_UNFINISHED);
                end
                else
                begin
                    add_beat(KIND_END, TOK_ARRAY_START, 8'h00, ERR_NUM_BOOL);
                end
            end
            else if (c == CH_COMMA && saw_digit && saw_bool_letter)
            begin
                // checked ahead of the string state
                stopped = 1'b1;
                add_beat(KIND_ERROR, TOK_ARRAY_START, 8'h00, ERR_NUM_BOOL);
            end
            else if (c == CH_QUOTE)
            begin
                if (inside_quotes)
                begin
                    inside_quotes = 1'b0;
                    value_open    = 1'b0;
                    add_beat(KIND_TOKEN, TOK_STRING, 8'h00, ERR_NUM_BOOL);
                end
                else
                begin
                    inside_quotes = 1'b1;
                end
            end
            else if (inside_quotes)
            begin
                keep_value_char(c);
            end
            else
            begin
                case (c)
                    CH_LCURLY: add_beat(KIND_TOKEN, TOK_CURLY_START, 8'h00, ERR_NUM_BOOL);
                    CH_LBRACK: add_beat(KIND_TOKEN, TOK_ARRAY_START, 8'h00, ERR_NUM_BOOL);
                    CH_COLON:  add_beat(KIND_TOKEN, TOK_COLON, 8'h00, ERR_NUM_BOOL);
                    CH_RCURLY: close_value(TOK_CURLY_END);
                    CH_RBRACK: close_value(TOK_ARRAY_END);
                    CH_COMMA:  close_value(TOK_COMMA);
                    CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                    default:   keep_value_char(c);
                endcase
            end
        end
        if (step_n > 0)
        begin
            step_beats[step_n - 1].last = 1'b1;
            result_items++;
        end
        for (int i = 0; i < step_n; i++)
            token_stream_q.insert(token_stream_q.size(), step_beats[i]);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One beat; valid stays up after acceptance until the next call or a drain
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_code    <= c;
        end_of_input <= eoi;
        // ready only moves at the clock edge, so look at it mid-cycle
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        tokenize_byte(c, eoi);
    endtask

    // Text byte that never trips the number/boolean comma error
    task automatic send_char(input logic [7:0] c);
        if (c == CH_COMMA && saw_digit && saw_bool_letter)
            send_beat(CH_RBRACK, 1'b0);
        else
            send_beat(c, 1'b0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Close strings and drain sticky flags so end of text is clean
    task automatic finish_open_value();
        if (inside_quotes)
            send_char(CH_QUOTE);
        while (saw_digit || saw_bool_letter || value_open)
        begin
            if (!value_open)
                send_char(CH_FILLER);
            else if ($urandom_range(1))
                send_char(CH_RBRACK);
            else
                send_char(CH_RCURLY);
        end
    endtask

    task automatic end_text();
        finish_open_value();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // Sender goes quiet until every predicted beat has been seen
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (token_stream_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        logic [7:0] b;
        case ($urandom_range(19))
            0:       b = CH_LCURLY;
            1:       b = CH_RCURLY;
            2:       b = CH_LBRACK;
            3:       b = CH_RBRACK;
            4:       b = CH_COLON;
            5:       b = CH_COMMA;
            6:       b = CH_QUOTE;
            7:       b = CH_MINUS;
            8:       b = CH_DOT;
            9:       b = CH_LOW_T;
            10:      b = CH_LOW_F;
            11:      b = CH_UP_T;
            12:      b = CH_UP_F;
            13:      b = CH_SPACE;
            14:      b = CH_TAB;
            15:      b = ($urandom_range(1)) ? CH_LF : CH_CR;
            16, 17:  b = 8'(CH_ZERO + $urandom_range(9));
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    task automatic send_json_string();
        logic [7:0] b;
        send_char(CH_QUOTE);
        repeat ($urandom_range(5))
        begin
            b = 8'($urandom_range(255));
            send_char((b == CH_QUOTE) ? CH_COLON : b);
        end
        send_char(CH_QUOTE);
    endtask

    // Random JSON value; nesting stops at depth 2
    task automatic send_json_value(input int depth);
        int pick;
        int count;
        pick = (depth >= 2) ? $urandom_range(3) : $urandom_range(5);
        case (pick)
            0:
            begin
                if ($urandom_range(1))
                    send_char(CH_MINUS);
                repeat ($urandom_range(1, 4))
                    send_char(8'(CH_ZERO + $urandom_range(9)));
                if ($urandom_range(3) == 0)
                begin
                    send_char(CH_DOT);
                    send_char(8'(CH_ZERO + $urandom_range(9)));
                end
            end
            1:
            begin
                case ($urandom_range(3))
                    0:       send_text("true");
                    1:       send_text("false");
                    2:       send_text("True");
                    default: send_text("F");
                endcase
            end
            2: send_text("null");
            3: send_json_string();
            4:
            begin
                count = $urandom_range(3);
                send_char(CH_LBRACK);
                for (int i = 0; i < count; i++)
                begin
                    if (i > 0)
                        send_char(CH_COMMA);
                    if ($urandom_range(3) == 0)
                        send_char(CH_SPACE);
                    send_json_value(depth + 1);
                end
                send_char(CH_RBRACK);
            end
            default:
            begin
                count = $urandom_range(3);
                send_char(CH_LCURLY);
                for (int i = 0; i < count; i++)
                begin
                    if (i > 0)
                        send_char(CH_COMMA);
                    send_json_string();
                    send_char(CH_COLON);
                    send_json_value(depth + 1);
                end
                send_char(CH_RCURLY);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Ready with random stalls plus the long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        out_ready <= (hold_req == hold_ack) && (hold_left == 0) &&
                     ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each result beat against the oldest predicted one; sampled
    // mid-cycle, so the beat seen here is the one taken at the next edge
    always @(negedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (token_stream_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat kind %0d tok %0d char %02h",
                                          result_kind, token_type, value_char));
            end
            else
            begin
                want = token_stream_q.pop_front();
                if (result_kind !== want.kind || token_type !== want.tok ||
                    value_char !== want.ch || error_code !== want.err ||
                    last !== want.last)
                    report_mismatch($sformatf(
                        "got k%0d t%0d c%02h e%0d l%0d, want k%0d t%0d c%02h e%0d l%0d",
                        result_kind, token_type, value_char, error_code, last,
                        want.kind, want.tok, want.ch, want.err, want.last));
            end
        end
    end

    // Cycles with no beat moving on either side
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        @(posedge clk);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every structural token plus string, number and boolean values
    task automatic test_structural_tokens();
        tx_idle_pct = 23;
        rx_idle_pct = 54;
        send_text("{\"k\":[-1,t]}");
        end_text();
    endtask

    // Delimiters in a string, bytes before a quote, whitespace, byte extremes,
    // null value, and a boolean flag left behind by a number close
    task automatic test_special_cases();
        send_text("a\"{]:,\"");
        send_text(" \t");
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CH_RBRACK);
        send_text("1t],x}");
        end_text();
    endtask

    task automatic test_random_text(input int tx_pct, input int rx_pct, input int target);
        int goal;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = result_items + target;
        while (result_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_json_value(0);
            else if (pick < 75)
                end_text();
            else if (pick < 95)
                repeat ($urandom_range(1, 6)) send_char(random_byte());
            else
                wait_results_drained();
        end
        end_text();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        wait_results_drained();
        hold_req <= ~hold_req;
        repeat (4) send_json_value(1);
        end_text();
        wait_results_drained();
    endtask

    // One error ends the run: everything after it must stay silent
    task automatic test_error_halt();
        finish_open_value();
        case ($urandom_range(2))
            0:
            begin
                send_beat(CH_NINE, 1'b0);
                send_beat(CH_UP_T, 1'b0);
                send_beat(CH_COMMA, 1'b0);
            end
            1:
            begin
                send_beat(CH_QUOTE, 1'b0);
                send_beat(CH_UP_F, 1'b0);
                send_beat(8'($urandom_range(255)), 1'b1);
            end
            default:
            begin
                send_beat(CH_MINUS, 1'b0);
                send_beat(8'($urandom_range(255)), 1'b1);
            end
        endcase
        repeat (6) send_beat(random_byte(), 1'($urandom_range(1)));
        send_beat(CH_LCURLY, 1'b1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_structural_tokens();
        test_special_cases();
        test_random_text(23, 54, 160);
        test_backpressure();
        test_random_text(54, 23, 160);
        test_random_text(0, 0, 160);
        test_error_halt();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
